>>> rtl/core/mexp_pkg.sv
package mexp_pkg;

  localparam int EXPONENT_BITS = 63;
  localparam int MODULUS_BITS  = 31;
  localparam int BASE_BITS     = 63;
  localparam int CNT_W         = $clog2(BASE_BITS > MODULUS_BITS ? BASE_BITS : MODULUS_BITS);
  localparam int BIT_W         = $clog2(MODULUS_BITS);

  localparam logic [MODULUS_BITS-1:0] MODULUS_RESET = MODULUS_BITS'(1000000007);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STEP,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic red_step;
    logic mul_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic red_last;
    logic mul_last;
    logic exp_zero;
    logic exp_last;
    logic out_busy;
  } sts_t;

endpackage

>>> rtl/core/mexp_ctrl.sv
module mexp_ctrl import mexp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  sts_t   sts_i,
  output cmd_t   cmd_o,
  output state_e state_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (sts_i.red_last) state_d = sts_i.exp_zero ? ST_FINISH : ST_STEP;
      end
      ST_STEP: begin
        if (sts_i.mul_last && sts_i.exp_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load    = in_valid_i;
      end
      ST_REDUCE: cmd_o.red_step = 1'b1;
      ST_STEP:   cmd_o.mul_step = 1'b1;
      ST_FINISH: cmd_o.out_load = !sts_i.out_busy;
      default:   cmd_o = '0;
    endcase
  end

  assign state_o = state_q;

endmodule

>>> rtl/core/mexp_dp.sv
module mexp_dp import mexp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  input  logic [MODULUS_BITS-1:0]  modulus_i,
  input  logic [BASE_BITS-1:0]     base_i,
  input  logic [EXPONENT_BITS-1:0] exponent_i,
  output logic [MODULUS_BITS-1:0]  result_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i
);

  logic [BASE_BITS-1:0]     x_q;
  logic [EXPONENT_BITS-1:0] e_q;
  logic [MODULUS_BITS-1:0]  b_q, acc_q, red_q, ra_q, rs_q, res_q;
  logic [MODULUS_BITS-1:0]  red_d, ra_d, rs_d;
  logic [CNT_W-1:0]         cnt_q;
  logic                     out_valid_q;
  logic                     b_bit;

  // one bit of a restoring remainder
  function automatic logic [MODULUS_BITS-1:0] red_bit(
    input logic [MODULUS_BITS-1:0] r,
    input logic                    bit_in,
    input logic [MODULUS_BITS-1:0] m
  );
    logic [MODULUS_BITS:0] t;
    t = {r, bit_in};
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    return t[MODULUS_BITS-1:0];
  endfunction

  // one bit of an interleaved modular product, r = 2r + bit*a mod m
  function automatic logic [MODULUS_BITS-1:0] mul_bit(
    input logic [MODULUS_BITS-1:0] r,
    input logic                    bit_in,
    input logic [MODULUS_BITS-1:0] a,
    input logic [MODULUS_BITS-1:0] m
  );
    logic [MODULUS_BITS+1:0] t, m1, m2, res;
    t  = {1'b0, r, 1'b0} + (bit_in ? {2'b00, a} : '0);
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    if (t >= m2)      res = t - m2;
    else if (t >= m1) res = t - m1;
    else              res = t;
    return res[MODULUS_BITS-1:0];
  endfunction

  assign b_bit = b_q[cnt_q[BIT_W-1:0]];
  assign red_d = red_bit(red_q, x_q[BASE_BITS-1], modulus_i);
  assign ra_d  = mul_bit(ra_q, b_bit, acc_q, modulus_i);
  assign rs_d  = mul_bit(rs_q, b_bit, b_q, modulus_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= CNT_W'(BASE_BITS - 1);
      end else if (cmd_i.red_step || cmd_i.mul_step) begin
        if (cnt_q == '0) cnt_q <= CNT_W'(MODULUS_BITS - 1);
        else             cnt_q <= cnt_q - CNT_W'(1);
      end
      if (cmd_i.out_load)    out_valid_q <= 1'b1;
      else if (out_ready_i)  out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= base_i;
      e_q   <= exponent_i;
      acc_q <= (modulus_i == MODULUS_BITS'(1)) ? '0 : MODULUS_BITS'(1);
      red_q <= '0;
    end
    if (cmd_i.red_step) begin
      x_q   <= x_q << 1;
      red_q <= red_d;
      if (cnt_q == '0) begin
        b_q  <= red_d;
        ra_q <= '0;
        rs_q <= '0;
      end
    end
    if (cmd_i.mul_step) begin
      if (cnt_q == '0) begin
        if (e_q[0]) acc_q <= ra_d;
        b_q  <= rs_d;
        e_q  <= e_q >> 1;
        ra_q <= '0;
        rs_q <= '0;
      end else begin
        ra_q <= ra_d;
        rs_q <= rs_d;
      end
    end
    if (cmd_i.out_load) begin
      res_q <= (modulus_i == '0) ? '0 : acc_q;
    end
  end

  assign sts_o.red_last = (cnt_q == '0);
  assign sts_o.mul_last = (cnt_q == '0);
  assign sts_o.exp_zero = (e_q == '0);
  assign sts_o.exp_last = ((e_q >> 1) == '0);
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  assign result_o    = res_q;
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/modular_exponentiation.sv
// channel   dir  word                                        accept
// s_axis    in   tdata[62:0] base, [125:63] exponent         tvalid & tready
// m_axis    out  tdata[30:0] power result                    tvalid & tready
// cfg       in   cfg_wr_data_i modulus                       cfg_wr_en_i
//
// one word runs a bit-serial reduction over all 63 base bits, then one pass per exponent
// bit up to and including the top set one, in two interleaved modular multipliers
// that scan the running base
// reset clears the controller and the output valid, modulus returns to 1000000007
// a new word is taken while a finished result waits; the result register holds
// until m_axis_tready, and the datapath waits in its last state when it is full
module modular_exponentiation import mexp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [127:0]            s_axis_tdata,   // base_value, exponent_value, zero pad
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [31:0]             m_axis_tdata,   // power_result, zero pad
  input  logic                    cfg_wr_en_i,
  input  logic [MODULUS_BITS-1:0] cfg_wr_data_i
);

  logic [MODULUS_BITS-1:0] modulus_q;
  logic [MODULUS_BITS-1:0] result;
  cmd_t                    cmd;
  sts_t                    sts;
  state_e                  state;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RESET;
    end else if (cfg_wr_en_i) begin
      modulus_q <= cfg_wr_data_i;
    end
  end

  mexp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  mexp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .modulus_i   (modulus_q),
    .base_i      (s_axis_tdata[BASE_BITS-1:0]),
    .exponent_i  (s_axis_tdata[BASE_BITS +: EXPONENT_BITS]),
    .result_o    (result),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {{(32 - MODULUS_BITS){1'b0}}, result};

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state != ST_IDLE) |-> !s_axis_tready)
    else $error("input taken while busy");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state == ST_REDUCE))
    else $error("accepted word did not start reduction");

  a_result_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (modulus_q != '0)) |-> (result < modulus_q))
    else $error("result not reduced");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.red_step, cmd.mul_step, cmd.out_load}))
    else $error("conflicting datapath commands");
`endif

endmodule

>>> tb/sv/modexp_checker.sv
`timescale 1ns / 100ps

module modexp_checker import mexp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  input  logic                    s_axis_tready,
  input  logic [127:0]            s_axis_tdata,
  input  logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  input  logic [31:0]             m_axis_tdata,
  input  logic                    cfg_wr_en_i,
  input  logic [MODULUS_BITS-1:0] cfg_wr_data_i,
  output int                      mismatch_count_o,
  output int                      pending_o
);

  logic [MODULUS_BITS-1:0] modulus_q;
  logic [MODULUS_BITS-1:0] expected_powers [$];
  logic [MODULUS_BITS-1:0] want_power;
  int                      mismatch_total = 0;
  int                      pending_q      = 0;

  assign mismatch_count_o = mismatch_total;
  assign pending_o        = pending_q;

  // square-and-multiply over 64-bit products, modulus below 2^31
  function automatic logic [MODULUS_BITS-1:0] modexp_power(
    input logic [62:0]             base_v,
    input logic [62:0]             expo_v,
    input logic [MODULUS_BITS-1:0] modulus_v
  );
    logic [63:0] acc;
    logic [63:0] running;
    logic [63:0] m;
    logic [62:0] e;
    if (modulus_v == '0) return '0;
    m       = 64'(modulus_v);
    running = {1'b0, base_v} % m;
    acc     = 64'd1;
    e       = expo_v & ((63'd1 << EXPONENT_BITS) - 63'd1);
    while (e != '0) begin
      if (e[0]) acc = (acc * running) % m;
      e       = e >> 1;
      running = (running * running) % m;
    end
    return MODULUS_BITS'(acc % m);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_total++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RESET;
      expected_powers.delete();
      pending_q <= 0;
    end else begin
      if (cfg_wr_en_i) begin
        modulus_q <= cfg_wr_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_powers.push_back(modexp_power(s_axis_tdata[62:0], s_axis_tdata[125:63],
                                               modulus_q));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_powers.size() == 0) begin
          report_mismatch($sformatf("unexpected word 0x%08h", m_axis_tdata));
        end else begin
          want_power = expected_powers.pop_front();
          if (m_axis_tdata !== {1'b0, want_power}) begin
            report_mismatch($sformatf("power_result got 0x%08h want 0x%08h",
                                      m_axis_tdata, {1'b0, want_power}));
          end
        end
      end
      pending_q <= expected_powers.size();
    end
  end

endmodule

>>> tb/sv/modular_exponentiation_test.sv
`timescale 1ns / 100ps

module modular_exponentiation_test;
  import mexp_pkg::*;

  localparam int CYCLE_LIMIT      = 10_000_000;
  localparam int HOLD_OFF_CYCLES  = 1500;
  localparam int RANDOM_PER_PHASE = 80;
  localparam int DRAIN_CYCLES     = 2100;
  localparam logic [62:0] MAX_FIELD = {63{1'b1}};

  logic                    clk_i;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [127:0]            s_axis_tdata  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [31:0]             m_axis_tdata;
  logic                    cfg_wr_en_i   = 1'b0;
  logic [MODULUS_BITS-1:0] cfg_wr_data_i = '0;

  int                      mismatch_count;
  int                      pending_powers;
  int unsigned             cycle_count   = 0;
  logic [MODULUS_BITS-1:0] modulus_now   = MODULUS_RESET;
  bit                      steady_run    = 1'b0;
  bit                      hold_off_req  = 1'b0;

  modular_exponentiation u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i)
  );

  modexp_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .cfg_wr_en_i      (cfg_wr_en_i),
    .cfg_wr_data_i    (cfg_wr_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_powers)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_idle();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  function automatic logic [62:0] random_base();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 63'($urandom_range(1, 10));
      2: return 63'(modulus_now) - 63'd1;
      3: return 63'(modulus_now) * 63'($urandom_range(1, 1000)) + 63'($urandom_range(0, 2));
      default: return wide[62:0];
    endcase
  endfunction

  // short exponents keep most words fast, a few use every bit
  function automatic logic [62:0] random_exponent(input int max_len);
    logic [63:0] wide;
    int          roll;
    int          len;
    wide = {$urandom, $urandom};
    roll = $urandom_range(0, 99);
    if (roll < 85) len = $urandom_range(0, 8);
    else if (roll < 95) len = $urandom_range(9, 20);
    else len = 63;
    if (len > max_len) len = max_len;
    return wide[62:0] & ((63'd1 << len) - 63'd1);
  endfunction

  task automatic send_word(input logic [62:0] base_v, input logic [62:0] expo_v,
                           input bit back_to_back);
    int gap;
    gap = (back_to_back || steady_run) ? 0 : pick_idle();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, expo_v, base_v};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_word(random_base(), random_exponent(63), 1'b0);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_powers != 0) @(posedge clk_i);
  endtask

  task automatic set_modulus(input logic [MODULUS_BITS-1:0] value);
    wait_idle();
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    modulus_now   = value;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
  endtask

  initial begin : result_sink
    int stretch;
    int stall;
    forever begin
      m_axis_tready <= 1'b1;
      stretch = steady_run ? 40 : $urandom_range(1, 30);
      repeat (stretch) @(posedge clk_i);
      if (hold_off_req) begin
        stall        = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end else begin
        stall = steady_run ? 0 : pick_idle();
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    logic [MODULUS_BITS-1:0] moduli [$];
    logic [62:0]             m_wide;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    m_wide = 63'(MODULUS_RESET);
    send_word('0, '0, 1'b0);
    send_word('0, 63'd1, 1'b0);
    send_word(MAX_FIELD, '0, 1'b0);
    send_word(MAX_FIELD, MAX_FIELD, 1'b0);
    send_word(63'd1, MAX_FIELD, 1'b0);
    send_word(m_wide - 63'd1, 63'd2, 1'b0);
    send_word(m_wide, 63'd5, 1'b0);
    send_word(m_wide + 63'd1, MAX_FIELD, 1'b0);
    send_word(63'd2, 63'd1 << 62, 1'b0);
    send_word(63'd2, 63'd30, 1'b0);
    send_word(63'd2, 63'd31, 1'b0);
    send_word(63'd3, {32{2'b01}}, 1'b0);
    send_word({32{2'b10}}, {32{2'b10}}, 1'b0);
    send_word(random_base(), 63'd1, 1'b0);
    send_word(m_wide * 63'd3 + 63'd7, 63'd100, 1'b0);
    run_random(RANDOM_PER_PHASE);

    moduli = '{31'd1, 31'd0, {MODULUS_BITS{1'b1}}, 31'd2, 31'd3, 31'd65537};
    moduli.push_back(31'($urandom));
    moduli.push_back(31'($urandom_range(4, 1000)));
    moduli.push_back(31'($urandom) | 31'h4000_0000);
    moduli.push_back(MODULUS_RESET);

    foreach (moduli[i]) begin
      set_modulus(moduli[i]);
      steady_run = (i == 4);
      if (moduli[i] == {MODULUS_BITS{1'b1}}) begin
        // sink holds off while words keep coming, so the block backs up
        hold_off_req = 1'b1;
        repeat (12) send_word(random_base(), random_exponent(3), 1'b1);
      end
      run_random(RANDOM_PER_PHASE);
      steady_run = 1'b0;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
